[rtl/slx_pkg.sv]
// Shared types, token kinds and character helpers for the script lexer.
package slx_pkg;

  localparam logic [62:0] VAL_MAX = {63{1'b1}};

  localparam logic [5:0] K_DOT    = 6'd7;
  localparam logic [5:0] K_MINUS  = 6'd8;
  localparam logic [5:0] K_DEC    = 6'd9;
  localparam logic [5:0] K_ARROW  = 6'd10;
  localparam logic [5:0] K_PLUS   = 6'd11;
  localparam logic [5:0] K_INC    = 6'd12;
  localparam logic [5:0] K_STAR   = 6'd14;
  localparam logic [5:0] K_SLASH  = 6'd26;
  localparam logic [5:0] K_STRING = 6'd27;
  localparam logic [5:0] K_INT    = 6'd28;
  localparam logic [5:0] K_FLOAT  = 6'd29;
  localparam logic [5:0] K_IDENT  = 6'd30;
  localparam logic [5:0] K_END    = 6'd31;
  localparam logic [5:0] K_ERROR  = 6'd32;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_BAD_CHAR = 3'd1;
  localparam logic [2:0] E_STRING   = 3'd2;
  localparam logic [2:0] E_COMMENT  = 3'd3;
  localparam logic [2:0] E_OVERFLOW = 3'd4;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [62:0] val;
    logic [2:0]  err;
    logic        last;
  } token_t;

  typedef struct packed {
    token_t [2:0] tok;
    logic   [1:0] cnt;
  } group_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_USCORE);
  endfunction

  // one-character tokens; bit 6 flags a hit
  function automatic logic [6:0] single_kind(input logic [7:0] c);
    case (c)
      8'h28:   return {1'b1, 6'd0};
      8'h29:   return {1'b1, 6'd1};
      8'h5B:   return {1'b1, 6'd2};
      8'h5D:   return {1'b1, 6'd3};
      8'h7B:   return {1'b1, 6'd4};
      8'h7D:   return {1'b1, 6'd5};
      8'h2C:   return {1'b1, 6'd6};
      CH_DOT:  return {1'b1, K_DOT};
      8'h3B:   return {1'b1, 6'd13};
      8'h3F:   return {1'b1, 6'd15};
      8'h7C:   return {1'b1, 6'd16};
      8'h3A:   return {1'b1, 6'd17};
      default: return 7'd0;
    endcase
  endfunction

  function automatic logic [5:0] cmp_base(input logic [7:0] c);
    if (c == CH_BANG) return 6'd18;
    if (c == CH_EQ) return 6'd20;
    if (c == CH_LT) return 6'd22;
    return 6'd24;
  endfunction

  function automatic token_t mk_tok(input logic [5:0] kind, input logic [15:0] start,
                                    input logic [15:0] len, input logic [15:0] line,
                                    input logic [62:0] val, input logic [2:0] err);
    token_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.val   = val;
    t.err   = err;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

[rtl/slx_if.sv]
// Byte input channel and token result channel interfaces.
interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;
  modport source (output valid, ch, end_of_source, input ready);
  modport sink (input valid, ch, end_of_source, output ready);
endinterface

interface slx_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  kind;
  logic [15:0] start_offset;
  logic [15:0] length;
  logic [15:0] line;
  logic [62:0] int_value;
  logic [2:0]  error_code;
  logic        last;
  modport source (output valid, kind, start_offset, length, line, int_value, error_code,
                  last, input ready);
  modport sink (input valid, kind, start_offset, length, line, int_value, error_code,
                last, output ready);
endinterface

[rtl/script_lexer_byte_stream_core.sv]
// Top level of the streaming script lexer: scanner, group queue, emitter.
// Path: a byte's tokens are written as a group into the queue, then loaded into the
// emitter's group register, which drives out_bus.
// Throughput: one byte per cycle while the queue has room; the emitter sends a byte's tokens
// one per transfer, and the two-group queue back-pressures the byte channel when it fills.
// Reset (rst_n low, synchronous): scanner idle, offset 0, first_line and line count 1,
// queue and output empty.
module script_lexer_byte_stream_core #(
  parameter int OFFSET_BITS       = 16,
  parameter int MAX_COMMENT_DEPTH = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  slx_in_if.sink      in_bus,
  slx_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  logic            q_push, q_full, q_pop, q_empty;
  slx_pkg::group_t q_wdata, q_rdata;

  slx_front #(.OFFSET_BITS(OFFSET_BITS), .MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata));

  slx_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata));

  slx_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
    .out_bus(out_bus));
endmodule

[rtl/slx_front.sv]
// Scanner front end: takes one byte per transfer and builds its token group.
module slx_front #(
  parameter int OFFSET_BITS       = 16,
  parameter int MAX_COMMENT_DEPTH = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  slx_in_if.sink           in_bus,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata,
  input  logic             q_full,
  output logic             q_push,
  output slx_pkg::group_t  q_data
);
  localparam int OB = OFFSET_BITS;
  localparam int DW = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam logic [DW-1:0] DMAX = DW'(MAX_COMMENT_DEPTH);

  localparam logic [3:0] M_IDLE = 4'd0, M_MINUS = 4'd1, M_PLUS = 4'd2, M_STAR = 4'd3,
                         M_CMP = 4'd4, M_SLASH = 4'd5, M_LINE_C = 4'd6, M_BLOCK = 4'd7,
                         M_BLOCK_STAR = 4'd8, M_BLOCK_SLASH = 4'd9, M_STRING = 4'd10,
                         M_INT = 4'd11, M_INT_DOT = 4'd12, M_FLOAT = 4'd13,
                         M_IDENT = 4'd14;

  logic [3:0]    mode_r, mode_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic [OB-1:0] tstart_r, tstart_nxt, pos_r, pos_nxt;
  logic [15:0]   line_r, line_nxt, first_r, len_r, len_nxt;
  logic [62:0]   acc_r, acc_nxt;
  logic          ovf_r, ovf_nxt;
  logic [DW-1:0] depth_r, depth_nxt;

  logic          fire, eos, consumed;
  logic [7:0]    c;
  logic [66:0]   prod;
  logic [15:0]   pos16, pos1_16, tst16, pm1_16;
  logic [OB-1:0] pos_inc;
  logic [6:0]    sk;
  slx_pkg::token_t [5:0] slot;
  logic [5:0]    sv;
  logic [1:0]    cnt;
  slx_pkg::group_t grp;

  assign in_bus.ready = !q_full;
  assign fire = in_bus.valid && in_bus.ready;
  assign c    = in_bus.ch;
  assign eos  = in_bus.end_of_source;
  assign prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + 67'(c - 8'h30);
  assign pos_inc = pos_r + OB'(1);
  assign pos16   = 16'(32'(pos_r));
  assign pos1_16 = 16'(32'(pos_inc));
  assign pm1_16  = 16'(32'(OB'(pos_r - OB'(1))));
  assign sk = slx_pkg::single_kind(c);

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    tstart_nxt = tstart_r;
    len_nxt   = len_r;
    line_nxt  = line_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    depth_nxt = depth_r;
    consumed  = 1'b0;
    sv        = '0;
    slot      = '0;
    tst16     = 16'(32'(tstart_r));

    // slots 0..1: tokens closed by the open lexeme, old line number
    case (mode_r)
      M_MINUS: begin
        if (c == slx_pkg::CH_MINUS || c == slx_pkg::CH_GT) begin
          len_nxt = sat_inc(len_r);
          consumed = 1'b1;
          mode_nxt = M_IDLE;
          slot[0] = slx_pkg::mk_tok((c == slx_pkg::CH_MINUS) ? slx_pkg::K_DEC :
                    slx_pkg::K_ARROW, tst16, len_nxt, line_r, '0, slx_pkg::E_NONE);
        end else begin
          slot[0] = slx_pkg::mk_tok(slx_pkg::K_MINUS, tst16, len_r, line_r, '0,
                                    slx_pkg::E_NONE);
        end
        sv[0] = 1'b1;
      end
      M_PLUS, M_STAR, M_CMP: begin
        if ((mode_r == M_PLUS && c == slx_pkg::CH_PLUS) ||
            (mode_r == M_STAR && c == slx_pkg::CH_STAR) ||
            (mode_r == M_CMP && c == slx_pkg::CH_EQ)) begin
          len_nxt = sat_inc(len_r);
          consumed = 1'b1;
          mode_nxt = M_IDLE;
        end
        slot[0] = slx_pkg::mk_tok(
          (mode_r == M_PLUS) ? (consumed ? slx_pkg::K_INC : slx_pkg::K_PLUS) :
          (mode_r == M_STAR) ? slx_pkg::K_STAR :
          slx_pkg::cmp_base(pend_r) + {5'd0, consumed},
          tst16, len_nxt, line_r, '0, slx_pkg::E_NONE);
        sv[0] = 1'b1;
      end
      M_SLASH: begin
        if (c == slx_pkg::CH_SLASH) begin
          len_nxt = sat_inc(len_r);
          consumed = 1'b1;
          mode_nxt = M_LINE_C;
        end else if (c == slx_pkg::CH_STAR) begin
          len_nxt = sat_inc(len_r);
          consumed = 1'b1;
          mode_nxt = M_BLOCK;
          depth_nxt = DW'(1);
        end else begin
          slot[0] = slx_pkg::mk_tok(slx_pkg::K_SLASH, tst16, len_r, line_r, '0,
                                    slx_pkg::E_NONE);
          sv[0] = 1'b1;
        end
      end
      M_LINE_C: begin
        consumed = 1'b1;
        if (c == slx_pkg::CH_NL) begin
          line_nxt = line_r + 16'd1;
          mode_nxt = M_IDLE;
        end
      end
      M_BLOCK, M_BLOCK_STAR, M_BLOCK_SLASH: begin
        consumed = 1'b1;
        len_nxt = sat_inc(len_r);
        if (mode_r == M_BLOCK_STAR && c == slx_pkg::CH_SLASH) begin
          depth_nxt = (depth_r != '0) ? depth_r - DW'(1) : depth_r;
          mode_nxt  = (depth_nxt == '0) ? M_IDLE : M_BLOCK;
        end else if (mode_r == M_BLOCK_SLASH && c == slx_pkg::CH_STAR) begin
          depth_nxt = (depth_r < DMAX) ? depth_r + DW'(1) : depth_r;
          mode_nxt  = M_BLOCK;
        end else if (c == slx_pkg::CH_NL) begin
          line_nxt = line_r + 16'd1;
          mode_nxt = M_BLOCK;
        end else if (c == slx_pkg::CH_STAR) begin
          mode_nxt = M_BLOCK_STAR;
        end else if (c == slx_pkg::CH_SLASH) begin
          mode_nxt = M_BLOCK_SLASH;
        end else begin
          mode_nxt = M_BLOCK;
        end
      end
      M_STRING: begin
        consumed = 1'b1;
        len_nxt = sat_inc(len_r);
        if (c == slx_pkg::CH_QUOTE) begin
          slot[0] = slx_pkg::mk_tok(slx_pkg::K_STRING, tst16, len_nxt, line_r, '0,
                                    slx_pkg::E_NONE);
          sv[0] = 1'b1;
          mode_nxt = M_IDLE;
        end else if (c == slx_pkg::CH_NL) begin
          line_nxt = line_r + 16'd1;
        end
      end
      M_INT, M_INT_DOT: begin
        if (slx_pkg::is_digit(c)) begin
          consumed = 1'b1;
          len_nxt = sat_inc(len_r);
          if (mode_r == M_INT_DOT) begin
            len_nxt = sat_inc(len_nxt);
            mode_nxt = M_FLOAT;
          end else if (!ovf_r) begin
            if (prod > {4'b0, slx_pkg::VAL_MAX}) begin
              ovf_nxt = 1'b1;
              acc_nxt = slx_pkg::VAL_MAX;
            end else begin
              acc_nxt = prod[62:0];
            end
          end
        end else if (mode_r == M_INT && c == slx_pkg::CH_DOT) begin
          consumed = 1'b1;
          mode_nxt = M_INT_DOT;
        end else begin
          slot[0] = ovf_r ?
            slx_pkg::mk_tok(slx_pkg::K_ERROR, tst16, len_r, line_r, slx_pkg::VAL_MAX,
                            slx_pkg::E_OVERFLOW) :
            slx_pkg::mk_tok(slx_pkg::K_INT, tst16, len_r, line_r, acc_r, slx_pkg::E_NONE);
          sv[0] = 1'b1;
          if (mode_r == M_INT_DOT) begin
            slot[1] = slx_pkg::mk_tok(slx_pkg::K_DOT, pm1_16, 16'd1, line_r, '0,
                                      slx_pkg::E_NONE);
            sv[1] = 1'b1;
          end
        end
      end
      M_FLOAT, M_IDENT: begin
        if (slx_pkg::is_digit(c) || (mode_r == M_IDENT && slx_pkg::is_alpha(c))) begin
          consumed = 1'b1;
          len_nxt = sat_inc(len_r);
        end else begin
          slot[0] = slx_pkg::mk_tok((mode_r == M_FLOAT) ? slx_pkg::K_FLOAT :
                    slx_pkg::K_IDENT, tst16, len_r, line_r, '0, slx_pkg::E_NONE);
          sv[0] = 1'b1;
        end
      end
      default: consumed = 1'b0;
    endcase

    // slot 2: the byte starts afresh
    if (!consumed) begin
      mode_nxt = M_IDLE;
      if (sk[6]) begin
        slot[2] = slx_pkg::mk_tok(sk[5:0], pos16, 16'd1, line_nxt, '0, slx_pkg::E_NONE);
        sv[2] = 1'b1;
      end else begin
        case (c)
          slx_pkg::CH_MINUS: mode_nxt = M_MINUS;
          slx_pkg::CH_PLUS:  mode_nxt = M_PLUS;
          slx_pkg::CH_STAR:  mode_nxt = M_STAR;
          slx_pkg::CH_BANG, slx_pkg::CH_EQ, slx_pkg::CH_LT, slx_pkg::CH_GT: begin
            mode_nxt = M_CMP;
            pend_nxt = c;
          end
          slx_pkg::CH_SLASH: mode_nxt = M_SLASH;
          slx_pkg::CH_SP, slx_pkg::CH_CR, slx_pkg::CH_TAB: mode_nxt = M_IDLE;
          slx_pkg::CH_NL:    line_nxt = line_r + 16'd1;
          slx_pkg::CH_QUOTE: mode_nxt = M_STRING;
          default: begin
            if (slx_pkg::is_digit(c)) begin
              mode_nxt = M_INT;
              acc_nxt = 63'(c - 8'h30);
              ovf_nxt = 1'b0;
            end else if (slx_pkg::is_alpha(c)) begin
              mode_nxt = M_IDENT;
            end else begin
              slot[2] = slx_pkg::mk_tok(slx_pkg::K_ERROR, pos16, 16'd1, line_nxt, '0,
                                        slx_pkg::E_BAD_CHAR);
              sv[2] = 1'b1;
            end
          end
        endcase
        if (mode_nxt != M_IDLE) begin
          tstart_nxt = pos_r;
          len_nxt = 16'd1;
        end
      end
    end

    // slots 3..5: flush of the open lexeme and the end token
    if (eos) begin
      tst16 = 16'(32'(tstart_nxt));
      case (mode_nxt)
        M_MINUS: slot[3] = slx_pkg::mk_tok(slx_pkg::K_MINUS, tst16, len_nxt, line_nxt,
                                           '0, slx_pkg::E_NONE);
        M_PLUS:  slot[3] = slx_pkg::mk_tok(slx_pkg::K_PLUS, tst16, len_nxt, line_nxt,
                                           '0, slx_pkg::E_NONE);
        M_STAR:  slot[3] = slx_pkg::mk_tok(slx_pkg::K_STAR, tst16, len_nxt, line_nxt,
                                           '0, slx_pkg::E_NONE);
        M_CMP:   slot[3] = slx_pkg::mk_tok(slx_pkg::cmp_base(pend_nxt), tst16, len_nxt,
                                           line_nxt, '0, slx_pkg::E_NONE);
        M_SLASH: slot[3] = slx_pkg::mk_tok(slx_pkg::K_SLASH, tst16, len_nxt, line_nxt,
                                           '0, slx_pkg::E_NONE);
        M_BLOCK, M_BLOCK_STAR, M_BLOCK_SLASH:
          slot[3] = slx_pkg::mk_tok(slx_pkg::K_ERROR, tst16, len_nxt, line_nxt, '0,
                                    slx_pkg::E_COMMENT);
        M_STRING: slot[3] = slx_pkg::mk_tok(slx_pkg::K_ERROR, tst16, len_nxt, line_nxt,
                                            '0, slx_pkg::E_STRING);
        M_INT, M_INT_DOT: slot[3] = ovf_nxt ?
          slx_pkg::mk_tok(slx_pkg::K_ERROR, tst16, len_nxt, line_nxt, slx_pkg::VAL_MAX,
                          slx_pkg::E_OVERFLOW) :
          slx_pkg::mk_tok(slx_pkg::K_INT, tst16, len_nxt, line_nxt, acc_nxt,
                          slx_pkg::E_NONE);
        M_FLOAT: slot[3] = slx_pkg::mk_tok(slx_pkg::K_FLOAT, tst16, len_nxt, line_nxt,
                                           '0, slx_pkg::E_NONE);
        M_IDENT: slot[3] = slx_pkg::mk_tok(slx_pkg::K_IDENT, tst16, len_nxt, line_nxt,
                                           '0, slx_pkg::E_NONE);
        default: slot[3] = '0;
      endcase
      sv[3] = (mode_nxt != M_IDLE) && (mode_nxt != M_LINE_C);
      if (mode_nxt == M_INT_DOT) begin
        slot[4] = slx_pkg::mk_tok(slx_pkg::K_DOT, pos16, 16'd1, line_nxt, '0,
                                  slx_pkg::E_NONE);
        sv[4] = 1'b1;
      end
      slot[5] = slx_pkg::mk_tok(slx_pkg::K_END, pos1_16, 16'd0, line_nxt, '0,
                                slx_pkg::E_NONE);
      slot[5].last = 1'b1;
      sv[5] = 1'b1;
    end

    // keep the first three tokens in order
    grp = '0;
    cnt = 2'd0;
    for (int i = 0; i < 6; i++) begin
      if (sv[i] && cnt != 2'd3) begin
        grp.tok[cnt] = slot[i];
        cnt = cnt + 2'd1;
      end
    end
    grp.cnt = cnt;
    if (eos && $countones(sv[4:0]) >= 3) grp.tok[2].last = 1'b1;
  end

  assign q_push = fire && (cnt != 2'd0);
  assign q_data = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pend_r   <= '0;
      tstart_r <= '0;
      pos_r    <= '0;
      first_r  <= 16'd1;
      line_r   <= 16'd1;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      depth_r  <= '0;
      len_r    <= '0;
    end else if (cfg_we) begin
      first_r <= cfg_wdata;
      line_r  <= cfg_wdata;
    end else if (fire) begin
      if (eos) begin
        mode_r   <= M_IDLE;
        pend_r   <= '0;
        tstart_r <= '0;
        pos_r    <= '0;
        line_r   <= first_r;
        acc_r    <= '0;
        ovf_r    <= 1'b0;
        depth_r  <= '0;
        len_r    <= '0;
      end else begin
        mode_r   <= mode_nxt;
        pend_r   <= pend_nxt;
        tstart_r <= tstart_nxt;
        pos_r    <= pos_inc;
        line_r   <= line_nxt;
        acc_r    <= acc_nxt;
        ovf_r    <= ovf_nxt;
        depth_r  <= depth_nxt;
        len_r    <= len_nxt;
      end
    end
  end

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && eos && !cfg_we |=> pos_r == '0 && mode_r == M_IDLE)
    else $error("state not cleared after final byte");
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DMAX) else $error("comment depth beyond limit");
endmodule

[rtl/slx_fifo.sv]
// Two-entry queue of token groups between scanner and emitter.
module slx_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  slx_pkg::group_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output slx_pkg::group_t rdata
);
  slx_pkg::group_t [1:0] mem_r;
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("pop from empty queue");
endmodule

[rtl/slx_back.sv]
// Emitter: unpacks queued token groups into single result transfers.
module slx_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  slx_pkg::group_t q_data,
  output logic            q_pop,
  slx_out_if.source       out_bus
);
  slx_pkg::group_t grp_r;
  logic            gvalid_r;
  logic [1:0]      idx_r;
  logic            fire, at_end;
  slx_pkg::token_t t;

  assign t      = grp_r.tok[idx_r];
  assign fire   = out_bus.valid && out_bus.ready;
  assign at_end = (idx_r == grp_r.cnt - 2'd1);
  assign q_pop  = !q_empty && (!gvalid_r || (fire && at_end));

  assign out_bus.valid        = gvalid_r;
  assign out_bus.kind         = t.kind;
  assign out_bus.start_offset = t.start;
  assign out_bus.length       = t.len;
  assign out_bus.line         = t.line;
  assign out_bus.int_value    = t.val;
  assign out_bus.error_code   = t.err;
  assign out_bus.last         = t.last;

  always_ff @(posedge clk) begin
    if (q_pop) grp_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gvalid_r <= 1'b0;
      idx_r    <= 2'd0;
    end else if (q_pop) begin
      gvalid_r <= 1'b1;
      idx_r    <= 2'd0;
    end else if (fire) begin
      if (at_end) gvalid_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    gvalid_r |-> (grp_r.cnt != 2'd0) && (idx_r < grp_r.cnt))
    else $error("token index outside group");
endmodule

[tb/testbench.sv]
// Self-checking testbench for the streaming script lexer: random sources, token scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    S_IDLE, S_MINUS, S_PLUS, S_STAR, S_CMP, S_SLASH, S_LINE_C, S_BLOCK, S_BLOCK_STAR,
    S_BLOCK_SLASH, S_STRING, S_INT, S_INT_DOT, S_FLOAT, S_IDENT
  } scan_t;

  localparam int        MAX_DEPTH = 15;
  localparam logic [63:0] SAT64   = {1'b0, slx_pkg::VAL_MAX};
  localparam logic [5:0] K_SEMI   = 6'd13;
  localparam logic [5:0] K_BANG   = 6'd18;
  localparam logic [5:0] K_EQUAL  = 6'd20;
  localparam logic [5:0] K_LESS   = 6'd22;
  localparam logic [5:0] K_GREAT  = 6'd24;
  localparam logic [5:0] K_NONE   = 6'd63;

  class token_scoreboard;
    slx_pkg::token_t expected_q[$];
    int          mismatches;
    logic [15:0] first_line;
    scan_t       mode;
    logic [7:0]  pend;
    logic [15:0] tok_start, byte_pos, line_cnt, lex_len;
    logic [63:0] accum;
    bit          overflow;
    int          depth;
    slx_pkg::token_t due[3];
    int          n_due;

    function new();
      mismatches = 0;
      first_line = 16'd1;
      clear_source();
    endfunction

    function void clear_source();
      mode = S_IDLE; pend = 0; tok_start = 0; byte_pos = 0; line_cnt = first_line;
      accum = 0; overflow = 0; depth = 0; lex_len = 0;
    endfunction

    function void set_first_line(logic [15:0] v);
      first_line = v;
      line_cnt = v;
    endfunction

    function void emit(logic [5:0] k, logic [15:0] s, logic [15:0] l, logic [62:0] v,
                       logic [2:0] e, logic lst);
      if (n_due >= 3) return;
      due[n_due] = '{kind: k, start: s, len: l, line: line_cnt, val: v, err: e, last: lst};
      n_due++;
    endfunction

    function void emit_lexeme(logic [5:0] k);
      emit(k, tok_start, lex_len, '0, slx_pkg::E_NONE, 1'b0);
    endfunction

    function void take();
      if (lex_len != 16'hFFFF) lex_len++;
    endfunction

    function void open_lexeme(scan_t m, logic [15:0] p);
      mode = m; tok_start = p; lex_len = 16'd1;
    endfunction

    function logic [5:0] op_kind(logic [7:0] c);
      case (c)
        "(": return 6'd0;  ")": return 6'd1;  "[": return 6'd2;  "]": return 6'd3;
        "{": return 6'd4;  "}": return 6'd5;  ",": return 6'd6;  ".": return slx_pkg::K_DOT;
        ";": return K_SEMI; "?": return 6'd15; "|": return 6'd16; ":": return 6'd17;
        default: return K_NONE;
      endcase
    endfunction

    function logic [5:0] compare_kind(logic [7:0] c);
      if (c == slx_pkg::CH_BANG) return K_BANG;
      if (c == slx_pkg::CH_EQ) return K_EQUAL;
      if (c == slx_pkg::CH_LT) return K_LESS;
      return K_GREAT;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == slx_pkg::CH_USCORE;
    endfunction

    function void add_digit(logic [7:0] c);
      logic [63:0] d;
      d = 64'(c - "0");
      if (overflow) return;
      if (accum > (SAT64 - d) / 10) begin
        overflow = 1;
        accum = SAT64;
      end else begin
        accum = accum * 10 + d;
      end
    endfunction

    function void finish_number();
      if (overflow)
        emit(slx_pkg::K_ERROR, tok_start, lex_len, slx_pkg::VAL_MAX, slx_pkg::E_OVERFLOW,
             1'b0);
      else emit(slx_pkg::K_INT, tok_start, lex_len, accum[62:0], slx_pkg::E_NONE, 1'b0);
    endfunction

    function void idle_byte(logic [7:0] c, logic [15:0] p);
      logic [5:0] k;
      k = op_kind(c);
      mode = S_IDLE;
      if (k != K_NONE) begin
        emit(k, p, 16'd1, '0, slx_pkg::E_NONE, 1'b0);
        return;
      end
      case (c)
        slx_pkg::CH_MINUS: open_lexeme(S_MINUS, p);
        slx_pkg::CH_PLUS:  open_lexeme(S_PLUS, p);
        slx_pkg::CH_STAR:  open_lexeme(S_STAR, p);
        slx_pkg::CH_BANG, slx_pkg::CH_EQ, slx_pkg::CH_LT, slx_pkg::CH_GT: begin
          open_lexeme(S_CMP, p);
          pend = c;
        end
        slx_pkg::CH_SLASH: open_lexeme(S_SLASH, p);
        slx_pkg::CH_SP, slx_pkg::CH_CR, slx_pkg::CH_TAB: ;
        slx_pkg::CH_NL:    line_cnt++;
        slx_pkg::CH_QUOTE: open_lexeme(S_STRING, p);
        default: begin
          if (digit(c)) begin
            open_lexeme(S_INT, p);
            accum = 0;
            overflow = 0;
            add_digit(c);
          end else if (letter(c)) begin
            open_lexeme(S_IDENT, p);
          end else begin
            emit(slx_pkg::K_ERROR, p, 16'd1, '0, slx_pkg::E_BAD_CHAR, 1'b0);
          end
        end
      endcase
    endfunction

    // 0 hands the byte back for scanning from idle
    function bit lexeme_byte(logic [7:0] c, logic [15:0] p);
      case (mode)
        S_MINUS: begin
          if (c == slx_pkg::CH_MINUS || c == slx_pkg::CH_GT) begin
            take();
            emit_lexeme(c == slx_pkg::CH_MINUS ? slx_pkg::K_DEC : slx_pkg::K_ARROW);
            mode = S_IDLE;
            return 1;
          end
          emit_lexeme(slx_pkg::K_MINUS); return 0;
        end
        S_PLUS: begin
          if (c == slx_pkg::CH_PLUS) begin
            take(); emit_lexeme(slx_pkg::K_INC); mode = S_IDLE; return 1;
          end
          emit_lexeme(slx_pkg::K_PLUS); return 0;
        end
        S_STAR: begin
          if (c == slx_pkg::CH_STAR) begin
            take(); emit_lexeme(slx_pkg::K_STAR); mode = S_IDLE; return 1;
          end
          emit_lexeme(slx_pkg::K_STAR); return 0;
        end
        S_CMP: begin
          if (c == slx_pkg::CH_EQ) begin
            take(); emit_lexeme(compare_kind(pend) + 6'd1); mode = S_IDLE; return 1;
          end
          emit_lexeme(compare_kind(pend)); return 0;
        end
        S_SLASH: begin
          if (c == slx_pkg::CH_SLASH) begin
            take(); mode = S_LINE_C; return 1;
          end
          if (c == slx_pkg::CH_STAR) begin
            take(); mode = S_BLOCK; depth = 1; return 1;
          end
          emit_lexeme(slx_pkg::K_SLASH); return 0;
        end
        S_LINE_C: begin
          if (c == slx_pkg::CH_NL) begin
            line_cnt++; mode = S_IDLE;
          end
          return 1;
        end
        S_BLOCK, S_BLOCK_STAR, S_BLOCK_SLASH: begin
          take();
          if (mode == S_BLOCK_STAR && c == slx_pkg::CH_SLASH) begin
            if (depth > 0) depth--;
            mode = (depth == 0) ? S_IDLE : S_BLOCK;
            return 1;
          end
          if (mode == S_BLOCK_SLASH && c == slx_pkg::CH_STAR) begin
            if (depth < MAX_DEPTH) depth++;
            mode = S_BLOCK;
            return 1;
          end
          mode = S_BLOCK;
          if (c == slx_pkg::CH_NL) line_cnt++;
          else if (c == slx_pkg::CH_STAR) mode = S_BLOCK_STAR;
          else if (c == slx_pkg::CH_SLASH) mode = S_BLOCK_SLASH;
          return 1;
        end
        S_STRING: begin
          take();
          if (c == slx_pkg::CH_QUOTE) begin
            emit_lexeme(slx_pkg::K_STRING); mode = S_IDLE;
          end else if (c == slx_pkg::CH_NL) begin
            line_cnt++;
          end
          return 1;
        end
        S_INT: begin
          if (digit(c)) begin
            take(); add_digit(c); return 1;
          end
          if (c == slx_pkg::CH_DOT) begin
            mode = S_INT_DOT; return 1;
          end
          finish_number(); return 0;
        end
        S_INT_DOT: begin
          if (digit(c)) begin
            take(); take(); mode = S_FLOAT; return 1;
          end
          finish_number();
          emit(slx_pkg::K_DOT, p - 16'd1, 16'd1, '0, slx_pkg::E_NONE, 1'b0);
          return 0;
        end
        S_FLOAT: begin
          if (digit(c)) begin
            take(); return 1;
          end
          emit_lexeme(slx_pkg::K_FLOAT); return 0;
        end
        S_IDENT: begin
          if (digit(c) || letter(c)) begin
            take(); return 1;
          end
          emit_lexeme(slx_pkg::K_IDENT); return 0;
        end
        default: return 0;
      endcase
    endfunction

    function void flush_source(logic [15:0] p);
      case (mode)
        S_MINUS: emit_lexeme(slx_pkg::K_MINUS);
        S_PLUS:  emit_lexeme(slx_pkg::K_PLUS);
        S_STAR:  emit_lexeme(slx_pkg::K_STAR);
        S_CMP:   emit_lexeme(compare_kind(pend));
        S_SLASH: emit_lexeme(slx_pkg::K_SLASH);
        S_BLOCK, S_BLOCK_STAR, S_BLOCK_SLASH:
          emit(slx_pkg::K_ERROR, tok_start, lex_len, '0, slx_pkg::E_COMMENT, 1'b0);
        S_STRING: emit(slx_pkg::K_ERROR, tok_start, lex_len, '0, slx_pkg::E_STRING, 1'b0);
        S_INT:   finish_number();
        S_INT_DOT: begin
          finish_number();
          emit(slx_pkg::K_DOT, p, 16'd1, '0, slx_pkg::E_NONE, 1'b0);
        end
        S_FLOAT: emit_lexeme(slx_pkg::K_FLOAT);
        S_IDENT: emit_lexeme(slx_pkg::K_IDENT);
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] c, logic eos);
      logic [15:0] p;
      p = byte_pos;
      n_due = 0;
      if (mode == S_IDLE || !lexeme_byte(c, p)) idle_byte(c, p);
      byte_pos = p + 16'd1;
      if (eos) begin
        flush_source(p);
        if (n_due < 3) emit(slx_pkg::K_END, byte_pos, 16'd0, '0, slx_pkg::E_NONE, 1'b1);
        else due[2].last = 1'b1;
        clear_source();
      end
      for (int i = 0; i < n_due; i++) expected_q.push_back(due[i]);
    endfunction

    function void check_token(slx_pkg::token_t got);
      slx_pkg::token_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("%0t: token with none expected: %p", $realtime, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.kind != want.kind || got.start != want.start || got.len != want.len ||
          got.line != want.line || got.val != want.val || got.err != want.err ||
          got.last != want.last) begin
        if (mismatches < 10)
          $display("%0t: token mismatch\n  expected %p\n  actual   %p", $realtime, want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk, rst_n, cfg_we;
  logic [15:0] cfg_wdata;
  slx_in_if  in_bus();
  slx_out_if out_bus();
  token_scoreboard scoreboard;
  int in_idle_pct, out_idle_pct, hold_cycles, sent;
  logic [7:0] src_q[$];

  script_lexer_byte_stream_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #800us;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random back-pressure plus an occasional long hold-off
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      scoreboard.check_token('{kind: out_bus.kind, start: out_bus.start_offset,
                               len: out_bus.length, line: out_bus.line,
                               val: out_bus.int_value, err: out_bus.error_code,
                               last: out_bus.last});
  end

  task automatic push_byte(logic [7:0] c, logic eos);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.ch <= c;
    in_bus.end_of_source <= eos;
    do @(posedge clk); while (!in_bus.ready);
    scoreboard.note_byte(c, eos);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_source();
    foreach (src_q[i]) push_byte(src_q[i], i == src_q.size() - 1);
    src_q.delete();
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  task automatic add_digits(int n);
    repeat (n) src_q.push_back(8'($urandom_range("9", "0")));
  endtask

  task automatic add_fragment();
    string ops;
    int k;
    ops = "(){}[],.;?|:-+*/!=<>";
    case ($urandom_range(9))
      0, 1: repeat ($urandom_range(2, 1)) src_q.push_back(ops[$urandom_range(ops.len() - 1)]);
      2: begin
        src_q.push_back("_");
        repeat ($urandom_range(5)) src_q.push_back(8'($urandom_range("z", "a")));
        if ($urandom_range(1)) add_digits(2);
      end
      3: begin
        k = $urandom_range(3);
        add_digits(k == 0 ? $urandom_range(25, 19) : $urandom_range(4, 1));
        if (k == 1) src_q.push_back(slx_pkg::CH_DOT);
        if (k == 2) begin
          src_q.push_back(slx_pkg::CH_DOT);
          add_digits($urandom_range(3, 1));
        end
      end
      4: begin
        src_q.push_back(slx_pkg::CH_QUOTE);
        add_text($urandom_range(1) ? "a b" : "x\n");
        if ($urandom_range(3) != 0) src_q.push_back(slx_pkg::CH_QUOTE);
      end
      5: add_text($urandom_range(1) ? "// c\n" : "//");
      6: begin
        k = $urandom_range(3) == 0 ? $urandom_range(18, 14) : $urandom_range(3, 1);
        repeat (k) add_text("/*");
        add_text("*\n/");
        repeat ($urandom_range(k + 1)) add_text("*/");
      end
      7: src_q.push_back($urandom_range(1) ? slx_pkg::CH_NL : slx_pkg::CH_SP);
      default: src_q.push_back(8'($urandom_range(255)));
    endcase
  endtask

  task automatic drain();
    while (scoreboard.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_first_line(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    scoreboard.set_first_line(v);
  endtask

  task automatic run_phase(int in_pct, int out_pct, int n, bit squeeze);
    int goal;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    goal = sent + n;
    while (sent < goal) begin
      repeat ($urandom_range(6, 1)) add_fragment();
      if (squeeze && sent > goal - n + 30 && hold_cycles == 0) begin
        hold_cycles = 300;
        squeeze = 0;
      end
      send_source();
    end
    in_bus.valid <= 1'b0;
    drain();
  endtask

  initial begin
    scoreboard = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.ch = '0;
    in_bus.end_of_source = 1'b0;
    hold_cycles = 0;
    sent = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: several operators, number ending in a dot, three tokens due at the end
    add_text("-->=!=<");
    send_source();
    add_text("a**/?\xff");
    send_source();
    add_text("7.x\"q");
    send_source();
    add_text("1.(");
    send_source();
    add_text("/*/**/");
    send_source();
    in_bus.valid <= 1'b0;
    drain();

    write_first_line(16'hFFFF);
    run_phase(8, 54, 100, 0);
    write_first_line(16'h0000);
    run_phase(54, 8, 100, 0);
    write_first_line(16'($urandom));
    run_phase(0, 0, 100, 1);

    if (scoreboard.mismatches == 0 && scoreboard.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
